@@ src/wps_pkg.sv @@
// Shared types, widths and register indexes of the waypoint stepper.
package wps_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int STEP_W    = 16;
  localparam int LEG_W     = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COORD_W;

  localparam int MAG_W      = COORD_W;
  localparam int SC_W       = COORD_W - 1;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int ROOT_W     = COORD_W;
  localparam int NUM_W      = ROOT_W + STEP_W;
  localparam int CNT_W      = $clog2(SC_W);
  localparam int ROOT_CNT_W = $clog2(ROOT_W);
  localparam int DIV_CNT_W  = $clog2(STEP_W);

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(33);

  localparam logic [CFG_IDX_W-1:0] CFG_START_X    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE_X   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE_Y   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_END_X      = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_END_Y      = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] CFG_USE_MIDDLE = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LEN   = CFG_IDX_W'(7);

  typedef struct packed {
    logic signed [COORD_W-1:0] current_x;
    logic signed [COORD_W-1:0] current_y;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] next_x;
    logic signed [COORD_W-1:0] next_y;
    logic                      moved;
    logic [LEG_W-1:0]          leg;
  } out_word_t;

endpackage

@@ src/waypoint_pingpong_stepper_core.sv @@
// Waypoint stepper top level: sequencer, serial squarer, target and leg logic.
//
// Input channel in_valid_i/in_ready_o carries one word with the present position.
// Output channel out_valid_o/out_ready_i returns one word per input: the new
// position, a moved flag and the path leg after the tick.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i.
// A word that reaches its target is answered after the squaring pass; a word
// that steps also goes through the square root and the divisions. The squares
// of both deltas and the products with step_length come from one bit-serial
// pass; the square root takes two radicand bits a cycle; both axis divisions
// run in parallel at one quotient bit a cycle. One word is worked on at a
// time; the next word is taken as soon as the sequencer is back in idle, even
// while the previous result still waits.
// If the receiver stalls, the result register holds its word and a finished
// second word waits in the sequencer until the register frees.
// Reset clears the leg to zero, the configuration to its defaults (all points
// at the origin, no middle point, step_length 33) and empties the output.
module waypoint_pingpong_stepper_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  wps_pkg::in_word_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output wps_pkg::out_word_t                out_data_o,
  input  logic                              cfg_we_i,
  input  logic [wps_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [wps_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int CW = wps_pkg::COORD_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_ARR  = 3'd3;
  localparam logic [2:0] S_SQRT = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  localparam logic [wps_pkg::MAG_W-1:0] ONE     = wps_pkg::MAG_W'(1) << wps_pkg::FRAC_BITS;
  localparam logic [wps_pkg::SQ_W-1:0]  ARR_LIM = wps_pkg::SQ_W'(1) << (2 * wps_pkg::FRAC_BITS);

  // configuration
  logic [CW-1:0]               start_x_q, start_y_q, middle_x_q, middle_y_q, end_x_q, end_y_q;
  logic                        use_middle_q;
  logic [wps_pkg::STEP_W-1:0]  step_q;

  // control
  logic [2:0]                  state_q;
  logic [wps_pkg::CNT_W-1:0]   cnt_q;
  logic [wps_pkg::LEG_W-1:0]   leg_q;
  logic                        out_valid_q;

  // datapath
  wps_pkg::in_word_t           cur_q;
  wps_pkg::out_word_t          res_q, out_q;
  logic                        negx_q, negy_q, near_q;
  logic [wps_pkg::SC_W-1:0]    sx_q, sy_q;
  logic [wps_pkg::SQ_W-1:0]    xs_q, ys_q, acc_q;
  logic [wps_pkg::STEP_W-1:0]  step_sr_q;
  logic [wps_pkg::NUM_W-1:0]   px_q, py_q;

  logic [CW-1:0]               tx, ty;
  logic signed [CW:0]          dx, dy;
  logic [wps_pkg::MAG_W-1:0]   ax, ay;
  logic                        big;
  logic [wps_pkg::SQ_W-1:0]    sum100;
  logic                        arrived;
  logic [wps_pkg::LEG_W-1:0]   leg_next;
  logic                        out_free;

  logic                        sqrt_start, sqrt_done;
  logic [wps_pkg::ROOT_W-1:0]  root;
  logic [wps_pkg::ROOT_W-1:0]  den;
  logic [wps_pkg::NUM_W-1:0]   num_x, num_y;
  logic                        div_start, div_done_x, div_done_y;
  logic [wps_pkg::STEP_W-1:0]  qx, qy;
  logic signed [CW-1:0]        nx, ny;

  function automatic logic signed [CW-1:0] step_sat(input logic signed [CW-1:0] c,
                                                    input logic neg,
                                                    input logic [wps_pkg::STEP_W-1:0] q);
    logic signed [CW+1:0] s;
    logic signed [CW+1:0] qe;
    qe = $signed({{(CW + 2 - wps_pkg::STEP_W){1'b0}}, q});
    s  = neg ? ($signed({{2{c[CW-1]}}, c}) - qe) : ($signed({{2{c[CW-1]}}, c}) + qe);
    if (s[CW+1:CW-1] != 3'b000 && s[CW+1:CW-1] != 3'b111) begin
      step_sat = s[CW+1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      step_sat = s[CW-1:0];
    end
  endfunction

  // target select
  always_comb begin
    if (use_middle_q) begin
      case (leg_q)
        2'd1: begin
          tx = end_x_q;
          ty = end_y_q;
        end
        2'd3: begin
          tx = start_x_q;
          ty = start_y_q;
        end
        default: begin
          tx = middle_x_q;
          ty = middle_y_q;
        end
      endcase
    end else if (leg_q == '0) begin
      tx = end_x_q;
      ty = end_y_q;
    end else begin
      tx = start_x_q;
      ty = start_y_q;
    end
  end

  assign dx   = $signed({tx[CW-1], tx}) - $signed({cur_q.current_x[CW-1], cur_q.current_x});
  assign dy   = $signed({ty[CW-1], ty}) - $signed({cur_q.current_y[CW-1], cur_q.current_y});
  assign ax   = dx[CW] ? wps_pkg::MAG_W'(-dx) : wps_pkg::MAG_W'(dx);
  assign ay   = dy[CW] ? wps_pkg::MAG_W'(-dy) : wps_pkg::MAG_W'(dy);
  assign big  = ax[wps_pkg::MAG_W-1] | ay[wps_pkg::MAG_W-1];

  // 100 * sum of squares
  assign sum100   = (acc_q << 6) + (acc_q << 5) + (acc_q << 2);
  assign arrived  = near_q && (sum100 < ARR_LIM);
  assign leg_next = use_middle_q ? (leg_q + 1'b1) : {1'b0, ~leg_q[0]};
  assign out_free = !out_valid_q || out_ready_i;

  assign sqrt_start = (state_q == S_ARR) && !arrived;
  assign div_start  = (state_q == S_SQRT) && sqrt_done;
  assign den        = (root == '0) ? wps_pkg::ROOT_W'(1) : root;
  assign num_x      = px_q + {{wps_pkg::STEP_W{1'b0}}, (root >> 1)};
  assign num_y      = py_q + {{wps_pkg::STEP_W{1'b0}}, (root >> 1)};
  assign nx         = step_sat(cur_q.current_x, negx_q, qx);
  assign ny         = step_sat(cur_q.current_y, negy_q, qy);

  wps_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (acc_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  wps_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_x),
    .den_i   (den),
    .done_o  (div_done_x),
    .quo_o   (qx)
  );

  wps_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_y),
    .den_i   (den),
    .done_o  (div_done_y),
    .quo_o   (qy)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q    <= '0;
      start_y_q    <= '0;
      middle_x_q   <= '0;
      middle_y_q   <= '0;
      end_x_q      <= '0;
      end_y_q      <= '0;
      use_middle_q <= 1'b0;
      step_q       <= wps_pkg::STEP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wps_pkg::CFG_START_X:    start_x_q    <= cfg_wdata_i;
        wps_pkg::CFG_START_Y:    start_y_q    <= cfg_wdata_i;
        wps_pkg::CFG_MIDDLE_X:   middle_x_q   <= cfg_wdata_i;
        wps_pkg::CFG_MIDDLE_Y:   middle_y_q   <= cfg_wdata_i;
        wps_pkg::CFG_END_X:      end_x_q      <= cfg_wdata_i;
        wps_pkg::CFG_END_Y:      end_y_q      <= cfg_wdata_i;
        wps_pkg::CFG_USE_MIDDLE: use_middle_q <= cfg_wdata_i[0];
        wps_pkg::CFG_STEP_LEN:   step_q       <= cfg_wdata_i[wps_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      leg_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          cnt_q   <= '0;
          state_q <= S_SQ;
        end
        S_SQ: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == wps_pkg::CNT_W'(wps_pkg::SC_W - 1)) begin
            state_q <= S_ARR;
          end
        end
        S_ARR: begin
          if (arrived) begin
            leg_q   <= leg_next;
            state_q <= S_OUT;
          end else begin
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done_x && div_done_y) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_OUT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cur_q <= in_data_i;
        end
      end
      S_PREP: begin
        negx_q    <= dx[CW];
        negy_q    <= dy[CW];
        near_q    <= (ax < ONE) && (ay < ONE);
        sx_q      <= big ? ax[wps_pkg::MAG_W-1:1] : ax[wps_pkg::SC_W-1:0];
        sy_q      <= big ? ay[wps_pkg::MAG_W-1:1] : ay[wps_pkg::SC_W-1:0];
        xs_q      <= wps_pkg::SQ_W'(big ? ax[wps_pkg::MAG_W-1:1] : ax[wps_pkg::SC_W-1:0]);
        ys_q      <= wps_pkg::SQ_W'(big ? ay[wps_pkg::MAG_W-1:1] : ay[wps_pkg::SC_W-1:0]);
        step_sr_q <= step_q;
        acc_q     <= '0;
        px_q      <= '0;
        py_q      <= '0;
      end
      S_SQ: begin
        acc_q     <= acc_q + (sx_q[0] ? xs_q : '0) + (sy_q[0] ? ys_q : '0);
        px_q      <= px_q + (step_sr_q[0] ? xs_q[wps_pkg::NUM_W-1:0] : '0);
        py_q      <= py_q + (step_sr_q[0] ? ys_q[wps_pkg::NUM_W-1:0] : '0);
        sx_q      <= sx_q >> 1;
        sy_q      <= sy_q >> 1;
        xs_q      <= xs_q << 1;
        ys_q      <= ys_q << 1;
        step_sr_q <= step_sr_q >> 1;
      end
      S_ARR: begin
        if (arrived) begin
          res_q.next_x <= cur_q.current_x;
          res_q.next_y <= cur_q.current_y;
          res_q.moved  <= 1'b0;
          res_q.leg    <= leg_next;
        end
      end
      S_FIN: begin
        res_q.next_x <= nx;
        res_q.next_y <= ny;
        res_q.moved  <= 1'b1;
        res_q.leg    <= leg_q;
      end
      S_OUT: begin
        if (out_free) begin
          out_q <= res_q;
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ src/wps_sqrt.sv @@
// Integer square root, two radicand bits per cycle.
module wps_sqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [wps_pkg::SQ_W-1:0]       rad_i,
  output logic                           done_o,
  output logic [wps_pkg::ROOT_W-1:0]     root_o
);

  localparam int REM_W = wps_pkg::ROOT_W + 2;

  logic                              busy_q;
  logic                              done_q;
  logic [wps_pkg::ROOT_CNT_W-1:0]    cnt_q;
  logic [wps_pkg::SQ_W-1:0]          rad_q;
  logic [REM_W-1:0]                  rem_q;
  logic [wps_pkg::ROOT_W-1:0]        root_q;
  logic [REM_W-1:0]                  rem_try;
  logic [REM_W-1:0]                  sub_try;
  logic                              ge;
  logic                              last;

  assign rem_try = {rem_q[REM_W-3:0], rad_q[wps_pkg::SQ_W-1 -: 2]};
  assign sub_try = {root_q, 2'b01};
  assign ge      = rem_try >= sub_try;
  assign last    = (cnt_q == wps_pkg::ROOT_CNT_W'(wps_pkg::ROOT_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= ge ? (rem_try - sub_try) : rem_try;
      root_q <= {root_q[wps_pkg::ROOT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

@@ src/wps_div.sv @@
// Restoring divider, one quotient bit per cycle, quotient known to fit STEP_W bits.
module wps_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [wps_pkg::NUM_W-1:0]      num_i,
  input  logic [wps_pkg::ROOT_W-1:0]     den_i,
  output logic                           done_o,
  output logic [wps_pkg::STEP_W-1:0]     quo_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [wps_pkg::DIV_CNT_W-1:0]     cnt_q;
  logic [wps_pkg::ROOT_W-1:0]        rem_q;
  logic [wps_pkg::ROOT_W-1:0]        den_q;
  logic [wps_pkg::STEP_W-1:0]        low_q;
  logic [wps_pkg::ROOT_W:0]          t;
  logic [wps_pkg::ROOT_W:0]          t_sub;
  logic                              ge;
  logic                              last;

  assign t     = {rem_q, low_q[wps_pkg::STEP_W-1]};
  assign ge    = t >= {1'b0, den_q};
  assign t_sub = t - {1'b0, den_q};
  assign last  = (cnt_q == wps_pkg::DIV_CNT_W'(wps_pkg::STEP_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[wps_pkg::NUM_W-1:wps_pkg::STEP_W];
      low_q <= num_i[wps_pkg::STEP_W-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? t_sub[wps_pkg::ROOT_W-1:0] : t[wps_pkg::ROOT_W-1:0];
      low_q <= {low_q[wps_pkg::STEP_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = low_q;

endmodule

@@ src/wps_checker.sv @@
// Port-level checks on the waypoint stepper, bound to the top level.
module wps_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input wps_pkg::out_word_t out_data_o
);

  logic [1:0]                 pend_q;
  logic [wps_pkg::LEG_W-1:0]  last_leg_q;
  logic                       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= '0;
      last_leg_q <= '0;
    end else begin
      if (in_acc && !out_acc) begin
        pend_q <= pend_q + 1'b1;
      end else if (!in_acc && out_acc) begin
        pend_q <= pend_q - 1'b1;
      end
      if (out_acc) begin
        last_leg_q <= out_data_o.leg;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word dropped or changed while stalled");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("output word without an accepted input word");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two words in flight");

  a_leg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (out_data_o.moved ? (out_data_o.leg == last_leg_q)
                                  : (out_data_o.leg != last_leg_q)))
    else $error("leg changed on a step or held on arrival");

endmodule

bind waypoint_pingpong_stepper_core wps_checker u_wps_checker (.*);

@@ verif/tb_top.sv @@
// Self-checking testbench for the waypoint stepper: directed corners, then random routes.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wps_pkg::*;

  localparam int      CLK_HALF        = 4;
  localparam int      RESET_CYCLES    = 11;
  localparam int      ITEMS_PER_PHASE = 583;
  localparam int      DRAIN_CYCLES    = 200;
  localparam int      WATCHDOG_LIMIT  = 4000;
  localparam longint  COORD_MAX       = 64'sh7FFF_FFFF;
  localparam longint  COORD_MIN       = -64'sh8000_0000;

  class waypoint_scoreboard;
    logic signed [COORD_W-1:0] start_x, start_y, middle_x, middle_y, end_x, end_y;
    logic                      use_middle;
    logic [STEP_W-1:0]         step_len;
    logic [LEG_W-1:0]          leg;
    out_word_t                 pending_moves[$];
    out_word_t                 last_move;
    int                        errors;

    function new();
      start_x    = '0;
      start_y    = '0;
      middle_x   = '0;
      middle_y   = '0;
      end_x      = '0;
      end_y      = '0;
      use_middle = 1'b0;
      step_len   = STEP_RESET;
      leg        = '0;
      last_move  = '0;
      errors     = 0;
    endfunction

    static function logic signed [COORD_W-1:0] clamp_coord(longint v);
      if (v > COORD_MAX) v = COORD_MAX;
      if (v < COORD_MIN) v = COORD_MIN;
      return v[COORD_W-1:0];
    endfunction

    static function longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_START_X:    start_x = data;
        CFG_START_Y:    start_y = data;
        CFG_MIDDLE_X:   middle_x = data;
        CFG_MIDDLE_Y:   middle_y = data;
        CFG_END_X:      end_x = data;
        CFG_END_Y:      end_y = data;
        CFG_USE_MIDDLE: use_middle = data[0];
        CFG_STEP_LEN:   step_len = data[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    function void current_target(output longint tx, output longint ty);
      if (use_middle) begin
        case (leg)
          2'd1: begin
            tx = end_x;
            ty = end_y;
          end
          2'd3: begin
            tx = start_x;
            ty = start_y;
          end
          default: begin
            tx = middle_x;
            ty = middle_y;
          end
        endcase
      end else if (leg == 2'd0) begin
        tx = end_x;
        ty = end_y;
      end else begin
        tx = start_x;
        ty = start_y;
      end
    endfunction

    function out_word_t step_toward(in_word_t w);
      longint          cx, cy, tx, ty, dx, dy;
      longint unsigned unit, ax, ay, sx, sy, root, mx, my;
      out_word_t       r;
      unit = 64'd1 << FRAC_BITS;
      cx = $signed(w.current_x);
      cy = $signed(w.current_y);
      current_target(tx, ty);
      dx = tx - cx;
      dy = ty - cy;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      if (ax < unit && ay < unit && 100 * (ax * ax + ay * ay) < (64'd1 << (2 * FRAC_BITS))) begin
        leg      = use_middle ? LEG_W'(leg + 1) : LEG_W'((leg + 1) % 2);
        r.next_x = w.current_x;
        r.next_y = w.current_y;
        r.moved  = 1'b0;
        r.leg    = leg;
      end else begin
        sx = ax;
        sy = ay;
        while ((sx >> SC_W) != 0 || (sy >> SC_W) != 0) begin
          sx >>= 1;
          sy >>= 1;
        end
        root = floor_sqrt(sx * sx + sy * sy);
        if (root == 0) root = 1;
        mx = (sx * step_len + root / 2) / root;
        my = (sy * step_len + root / 2) / root;
        r.next_x = clamp_coord((dx < 0) ? cx - longint'(mx) : cx + longint'(mx));
        r.next_y = clamp_coord((dy < 0) ? cy - longint'(my) : cy + longint'(my));
        r.moved  = 1'b1;
        r.leg    = leg;
      end
      return r;
    endfunction

    function void log_position(in_word_t w);
      last_move = step_toward(w);
      pending_moves.push_back(last_move);
    endfunction

    function int pending();
      return pending_moves.size();
    endfunction

    function void check_move(out_word_t got);
      out_word_t want;
      if (pending_moves.size() == 0) begin
        $error("result word with nothing outstanding: next_x %0d next_y %0d",
               got.next_x, got.next_y);
        errors++;
        return;
      end
      want = pending_moves.pop_front();
      if (got.next_x !== want.next_x) begin
        $error("next_x: expected %0d, got %0d", want.next_x, got.next_x);
        errors++;
      end
      if (got.next_y !== want.next_y) begin
        $error("next_y: expected %0d, got %0d", want.next_y, got.next_y);
        errors++;
      end
      if (got.moved !== want.moved) begin
        $error("moved: expected %0d, got %0d", want.moved, got.moved);
        errors++;
      end
      if (got.leg !== want.leg) begin
        $error("leg: expected %0d, got %0d", want.leg, got.leg);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  in_word_t               in_data_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  out_word_t              out_data_o;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i;

  waypoint_scoreboard sb = new();
  int unsigned        send_idle = 0;
  int unsigned        recv_idle = 0;
  int                 quiet_cycles = 0;

  waypoint_pingpong_stepper_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_move(out_data_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL waypoint_pingpong_stepper_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic longint any_coord();
    return longint'($signed($urandom()));
  endfunction

  function automatic longint spread(int unsigned m);
    return longint'($urandom_range(2 * m)) - longint'(m);
  endfunction

  function automatic in_word_t at_pos(longint x, longint y);
    in_word_t w;
    w.current_x = waypoint_scoreboard::clamp_coord(x);
    w.current_y = waypoint_scoreboard::clamp_coord(y);
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    if ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.log_position(w);
  endtask

  task automatic send_near(longint ox, longint oy);
    longint tx, ty;
    sb.current_target(tx, ty);
    send_word(at_pos(tx + ox, ty + oy));
  endtask

  // hold the input off until every outstanding word has come back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic shuffle_route();
    longint      base_x, base_y;
    int unsigned span;
    longint      px[3], py[3];
    int unsigned kind;
    kind   = $urandom_range(3);
    base_x = any_coord() >>> 1;
    base_y = any_coord() >>> 1;
    span   = (kind == 3) ? 32'd20000 : (32'd1 << 20);
    for (int i = 0; i < 3; i++) begin
      case (kind)
        1: begin
          case ($urandom_range(3))
            0: px[i] = COORD_MIN;
            1: px[i] = COORD_MAX;
            2: px[i] = 0;
            default: px[i] = any_coord();
          endcase
          case ($urandom_range(3))
            0: py[i] = COORD_MIN;
            1: py[i] = COORD_MAX;
            2: py[i] = 0;
            default: py[i] = any_coord();
          endcase
        end
        2: begin
          px[i] = any_coord();
          py[i] = any_coord();
        end
        default: begin
          px[i] = base_x + spread(span);
          py[i] = base_y + spread(span);
        end
      endcase
    end
    cfg_write(CFG_START_X, CFG_DATA_W'(px[0]));
    cfg_write(CFG_START_Y, CFG_DATA_W'(py[0]));
    cfg_write(CFG_MIDDLE_X, CFG_DATA_W'(px[1]));
    cfg_write(CFG_MIDDLE_Y, CFG_DATA_W'(py[1]));
    cfg_write(CFG_END_X, CFG_DATA_W'(px[2]));
    cfg_write(CFG_END_Y, CFG_DATA_W'(py[2]));
    cfg_write(CFG_USE_MIDDLE, CFG_DATA_W'($urandom_range(1)));
    case ($urandom_range(9))
      0: cfg_write(CFG_STEP_LEN, '0);
      1: cfg_write(CFG_STEP_LEN, CFG_DATA_W'(16'hFFFF));
      2: cfg_write(CFG_STEP_LEN, CFG_DATA_W'($urandom_range(1, 255)));
      default: cfg_write(CFG_STEP_LEN, CFG_DATA_W'($urandom_range(4096, 65535)));
    endcase
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_random_item();
    int unsigned pick;
    longint      rad;
    pick = $urandom_range(99);
    if (pick < 55) begin
      // carry on walking from the last predicted position
      send_word(at_pos($signed(sb.last_move.next_x), $signed(sb.last_move.next_y)));
    end else if (pick < 75) begin
      send_near(spread(4600), spread(4600));
    end else if (pick < 85) begin
      rad = longint'($urandom_range(6500, 6600));
      if ($urandom_range(1)) rad = -rad;
      if ($urandom_range(1)) send_near(rad, spread(300));
      else send_near(spread(300), rad);
    end else begin
      send_word(at_pos(any_coord(), any_coord()));
    end
  endtask

  initial begin
    int left_in_route;
    left_in_route = 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset route: every point at the origin
    send_word(at_pos(0, 0));
    send_word(at_pos(6553, 0));
    send_word(at_pos(6554, 0));
    send_word(at_pos(0, -65536));
    send_word(at_pos(COORD_MIN, COORD_MIN));

    settle();
    cfg_write(CFG_START_X, CFG_DATA_W'(COORD_MIN));
    cfg_write(CFG_START_Y, CFG_DATA_W'(COORD_MIN));
    cfg_write(CFG_END_X, CFG_DATA_W'(COORD_MAX));
    cfg_write(CFG_END_Y, CFG_DATA_W'(COORD_MAX));
    cfg_write(CFG_STEP_LEN, CFG_DATA_W'(16'hFFFF));
    cfg_we_i <= 1'b0;
    send_word(at_pos(COORD_MAX - 7000, COORD_MAX - 7000));
    send_word(at_pos(COORD_MIN, COORD_MAX));
    send_near(0, 0);
    send_word(at_pos(COORD_MIN + 7000, COORD_MIN + 7000));
    send_word(at_pos(COORD_MAX, COORD_MIN));

    settle();
    cfg_write(CFG_STEP_LEN, '0);
    cfg_we_i <= 1'b0;
    send_word(at_pos(12345, -54321));

    settle();
    cfg_write(CFG_MIDDLE_X, CFG_DATA_W'(100000));
    cfg_write(CFG_MIDDLE_Y, CFG_DATA_W'(-100000));
    cfg_write(CFG_USE_MIDDLE, CFG_DATA_W'(1));
    cfg_write(CFG_STEP_LEN, CFG_DATA_W'(1000));
    cfg_we_i <= 1'b0;
    send_near(-4000, 4000);
    send_near(100, -100);
    send_word(at_pos(0, 0));

    // legs 3 and 2 with the middle point switched off
    settle();
    cfg_write(CFG_USE_MIDDLE, '0);
    cfg_we_i <= 1'b0;
    send_word(at_pos(0, 0));
    send_near(0, 0);

    settle();
    cfg_write(CFG_USE_MIDDLE, CFG_DATA_W'(1));
    cfg_we_i <= 1'b0;
    send_near(0, 0);
    send_near(0, 0);

    settle();
    cfg_write(CFG_USE_MIDDLE, '0);
    cfg_we_i <= 1'b0;
    send_word(at_pos(5, 5));
    send_near(-6553, 0);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle = 33;
          recv_idle = 88;
        end
        1: begin
          send_idle = 88;
          recv_idle = 33;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (left_in_route == 0) begin
          settle();
          shuffle_route();
          left_in_route = $urandom_range(40, 120);
        end
        send_random_item();
        left_in_route--;
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS waypoint_pingpong_stepper_core");
    end else begin
      $display("FAIL waypoint_pingpong_stepper_core");
    end
    $finish;
  end

endmodule
